@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLLI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLLI_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/plli_pkg.sv @@
package plli_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [DATA_W-1:0] DATA_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_LOW    = 3'd1,
    ST_HIGH   = 3'd2,
    ST_NOSEG  = 3'd3,
    ST_EMPTY  = 3'd4,
    ST_WRITE  = 3'd5
  } status_t;

endpackage

@@ hw/rtl/plli_if.sv @@
interface plli_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [plli_pkg::IDX_W-1:0]  entry_index;
  logic signed [plli_pkg::DATA_W-1:0] entry_x;
  logic signed [plli_pkg::DATA_W-1:0] entry_y;
  logic signed [plli_pkg::DATA_W-1:0] query_value;

  modport source (output valid, req_type, entry_index, entry_x, entry_y, query_value,
                  input ready);
  modport sink (input valid, req_type, entry_index, entry_x, entry_y, query_value,
                output ready);
endinterface

interface plli_rsp_if;
  logic                        valid;
  logic                        ready;
  logic signed [plli_pkg::DATA_W-1:0] result_value;
  logic [2:0]                  status;
  logic [plli_pkg::IDX_W-1:0]  segment_used;

  modport source (output valid, result_value, status, segment_used, input ready);
  modport sink (input valid, result_value, status, segment_used, output ready);
endinterface

interface plli_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [plli_pkg::CNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/plli_ram.sv @@
module plli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/piecewise_linear_lut_interp_core.sv @@
// Piecewise-linear interpolation over a table of up to TABLE_POINTS (x, y)
// breakpoints in signed Q16.16, held in one RAM that is read one entry per
// cycle. A write word stores one breakpoint and is answered, as are a query
// on an empty table and a clamped query. An interpolating query scans
// segments left to right, one table read per cycle, then runs one 32x32
// multiply and a restoring divider that yields one quotient bit per cycle.
// A query with no usable segment scans up to the last point in use,
// points_in_use capped at TABLE_POINTS. The block takes one word at a time;
// a finished result waits in the output register while the next word is
// accepted.
// points_in_use must be written over the cfg channel only while the block
// is idle; the block itself does not enforce this. Values above TABLE_POINTS
// act as TABLE_POINTS. Table entries read before they are written return
// arbitrary data.
`include "assert_macros.svh"

module piecewise_linear_lut_interp_core #(
  parameter int TABLE_POINTS = 16
) (
  input logic        clk,
  input logic        rst,
  plli_req_if.sink   req,
  plli_rsp_if.source rsp,
  plli_cfg_if.sink   cfg
);

  localparam int DW = plli_pkg::DATA_W;
  localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
  localparam int DCW = $clog2(DW);

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_LAST, S_FIRST, S_SCAN, S_MUL, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t state;

  logic [plli_pkg::CNT_W-1:0] points;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              k;
  logic [AW-1:0]              seg;
  logic signed [DW-1:0]       q;
  logic signed [DW-1:0]       xa;
  logic signed [DW-1:0]       ya;
  logic [DW-1:0]              yl;
  logic signed [DW-1:0]       xl;
  logic [DW-1:0]              dq;
  logic [DW-1:0]              mag;
  logic [DW-1:0]              span;
  logic                       neg;
  logic [2*DW-1:0]            acc;
  logic [DCW-1:0]             div_cnt;

  logic [DW-1:0]              res_value;
  plli_pkg::status_t          res_status;
  logic [plli_pkg::IDX_W-1:0] res_seg;

  logic                       rsp_valid;
  logic [DW-1:0]              rsp_value;
  logic [2:0]                 rsp_status;
  logic [plli_pkg::IDX_W-1:0] rsp_seg;

  // table memory: x in the high half, y in the low half
  logic                       ram_we;
  logic [2*DW-1:0]            ram_rdata;

  logic                       req_fire;
  logic [AW-1:0]              last_calc;
  logic signed [DW-1:0]       cur_x;
  logic signed [DW-1:0]       cur_y;
  logic                       hit;
  logic [DW:0]                span_w;
  logic [DW:0]                dq_w;
  logic [DW:0]                dy_w;
  logic [DW:0]                dy_neg;
  logic [DW:0]                trial;
  logic [DW+1:0]              r_w;
  logic [2*DW-1:0]            prod;

  assign req.ready   = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign req_fire    = req.valid && req.ready;
  assign ram_we      = req_fire && (req.req_type == plli_pkg::REQ_WRITE) &&
                       (int'(req.entry_index) < TABLE_POINTS);

  assign rsp.valid        = rsp_valid;
  assign rsp.result_value = rsp_value;
  assign rsp.status       = rsp_status;
  assign rsp.segment_used = rsp_seg;

  plli_ram #(
    .WIDTH (2 * DW),
    .DEPTH (TABLE_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req.entry_index)),
    .wdata ({req.entry_x, req.entry_y}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (int'(points) >= TABLE_POINTS) begin
      last_calc = AW'(TABLE_POINTS - 1);
    end else begin
      last_calc = AW'(int'(points) - 1);
    end
    cur_x  = signed'(ram_rdata[2*DW-1:DW]);
    cur_y  = signed'(ram_rdata[DW-1:0]);
    hit    = (q >= xa) && (q <= cur_x) && (cur_x > xa);
    span_w = {cur_x[DW-1], cur_x} - {xa[DW-1], xa};
    dq_w   = {q[DW-1], q} - {xa[DW-1], xa};
    dy_w   = {cur_y[DW-1], cur_y} - {ya[DW-1], ya};
    dy_neg = -dy_w;
    prod   = (2*DW)'(dq) * (2*DW)'(mag);
    // partial remainder shifted left by one, less the divisor
    trial  = acc[2*DW-1:DW-1] - {1'b0, span};
    if (neg) begin
      r_w = {{2{ya[DW-1]}}, ya} - {2'b00, acc[DW-1:0]};
    end else begin
      r_w = {{2{ya[DW-1]}}, ya} + {2'b00, acc[DW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      points    <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        points <= cfg.data;
      end
      // a new word loaded in S_EMIT keeps the output valid
      if (rsp_valid && rsp.ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            q        <= req.query_value;
            last_idx <= last_calc;
            rd_addr  <= last_calc;
            res_seg  <= '0;
            if (req.req_type == plli_pkg::REQ_WRITE) begin
              res_value  <= '0;
              res_status <= plli_pkg::ST_WRITE;
              state      <= S_EMIT;
            end else if (points == '0) begin
              res_value  <= '0;
              res_status <= plli_pkg::ST_EMPTY;
              state      <= S_EMIT;
            end else begin
              state <= S_WAIT;
            end
          end
        end

        S_WAIT: begin
          rd_addr <= '0;
          state   <= S_LAST;
        end

        S_LAST: begin
          xl      <= cur_x;
          yl      <= cur_y;
          rd_addr <= AW'(1);
          state   <= S_FIRST;
        end

        S_FIRST: begin
          if (rd_addr != last_idx) begin
            rd_addr <= rd_addr + AW'(1);
          end
          if (q <= cur_x) begin
            res_value  <= cur_y;
            res_status <= plli_pkg::ST_LOW;
            state      <= S_EMIT;
          end else if (q >= xl) begin
            res_value  <= yl;
            res_status <= plli_pkg::ST_HIGH;
            state      <= S_EMIT;
          end else begin
            xa    <= cur_x;
            ya    <= cur_y;
            k     <= AW'(1);
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rd_addr != last_idx) begin
            rd_addr <= rd_addr + AW'(1);
          end
          if (hit) begin
            span  <= span_w[DW-1:0];
            dq    <= dq_w[DW-1:0];
            neg   <= dy_w[DW];
            mag   <= dy_w[DW] ? dy_neg[DW-1:0] : dy_w[DW-1:0];
            seg   <= k - AW'(1);
            state <= S_MUL;
          end else if (k == last_idx) begin
            res_value  <= yl;
            res_status <= plli_pkg::ST_NOSEG;
            state      <= S_EMIT;
          end else begin
            xa <= cur_x;
            ya <= cur_y;
            k  <= k + AW'(1);
          end
        end

        S_MUL: begin
          acc     <= prod;
          div_cnt <= DCW'(DW - 1);
          state   <= S_DIV;
        end

        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (!trial[DW]) begin
            acc <= {trial[DW-1:0], acc[DW-2:0], 1'b1};
          end else begin
            acc <= {acc[2*DW-2:0], 1'b0};
          end
          if (div_cnt == '0) begin
            state <= S_FIN;
          end else begin
            div_cnt <= div_cnt - DCW'(1);
          end
        end

        S_FIN: begin
          if (r_w[DW+1:DW-1] == 3'b000 || r_w[DW+1:DW-1] == 3'b111) begin
            res_value <= r_w[DW-1:0];
          end else if (r_w[DW+1]) begin
            res_value <= plli_pkg::DATA_MIN;
          end else begin
            res_value <= plli_pkg::DATA_MAX;
          end
          res_status <= plli_pkg::ST_INTERP;
          res_seg    <= plli_pkg::IDX_W'(seg);
          state      <= S_EMIT;
        end

        S_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_value  <= res_value;
            rsp_status <= res_status;
            rsp_seg    <= res_seg;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // quotient must fit 32 bits: high half of the product below the divisor
  `PLLI_ASSERT_NXT(a_div_fits, clk, rst, state == S_MUL,
                   acc[2*DW-1:DW] < span, "product overflows divider")

  `PLLI_ASSERT_IMP(a_div_rem, clk, rst, state == S_FIN,
                   acc[2*DW-1:DW] < span, "remainder not below divisor")

  `PLLI_ASSERT_IMP(a_seg_range, clk, rst, state == S_FIN,
                   seg < last_idx, "segment beyond last point")

  `PLLI_ASSERT_NXT(a_empty, clk, rst,
                   req_fire && req.req_type == plli_pkg::REQ_QUERY && points == '0,
                   state == S_EMIT && res_status == plli_pkg::ST_EMPTY,
                   "empty table query mishandled")

endmodule
